// ===== hw/rtl/dome_mesh_vertex_face_generator_assert.svh =====
// Assertion macros used by the dome mesh generator top level.
`ifndef DOME_MESH_VERTEX_FACE_GENERATOR_ASSERT_SVH
`define DOME_MESH_VERTEX_FACE_GENERATOR_ASSERT_SVH

// Checked only while out of reset.
`define DMVF_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dmvf assertion failed");

// Checked at every edge, reset included.
`define DMVF_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("dmvf assertion failed");

`endif

// ===== hw/rtl/dmvf_pkg.sv =====
// Shared types, constants and codes of the dome mesh vertex and face generator.
package dmvf_pkg;

  localparam int unsigned MAX_RESOLUTION = 64;
  localparam int unsigned MAX_RINGS      = 64;

  // square root pipeline: 32-bit radicand, one result bit per stage
  localparam int unsigned SQ_IN_W  = 32;
  localparam int unsigned SQ_OUT_W = 16;
  localparam int unsigned SQ_STEPS = 16;

  // restoring divider: one quotient bit per stage
  localparam int unsigned DIV_NUM_W = 32;
  localparam int unsigned DIV_DEN_W = 17;
  localparam int unsigned DIV_Q_W   = 15;
  localparam int unsigned DIV_W     = 48;

  // pipeline stage map (index of the side-band register holding the item)
  localparam int unsigned Y_ST    = 2;
  localparam int unsigned R_ST    = 20;
  localparam int unsigned X_ST    = 23;
  localparam int unsigned TV_ST   = 18;
  localparam int unsigned TU_ST   = 39;
  localparam int unsigned LAST_ST = 41;
  localparam int unsigned DEPTH   = 42;

  localparam int unsigned TDATA_OUT_W = 168;

  typedef enum logic [1:0] {
    ST_VERTEX = 2'd0,
    ST_FACES  = 2'd1,
    ST_ERROR  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_RADIUS     = 2'd0,
    REG_RESOLUTION = 2'd1,
    REG_RING_COUNT = 2'd2
  } cfg_reg_e;

  // per-item side band carried down the pipeline
  typedef struct packed {
    logic             err;
    logic             back;
    logic             xneg;
    logic             first;
    logic [6:0]       cmag;
    logic [5:0][13:0] corner;
    logic [15:0]      y;
    logic [15:0]      xmag;
    logic [14:0]      texv;
    logic [14:0]      texu;
  } side_t;

  typedef struct packed {
    logic [TDATA_OUT_W-1:0] tdata;
    logic [1:0]             tuser;
  } out_t;

endpackage

// ===== hw/rtl/dmvf_isqrt.sv =====
// Pipelined integer square root, floor, one result bit per stage.
module dmvf_isqrt import dmvf_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [SQ_IN_W-1:0]  rad_i,
  output logic [SQ_OUT_W-1:0] root_o
);

  logic [SQ_IN_W-1:0] rem_q [SQ_STEPS];
  logic [SQ_IN_W-1:0] acc_q [SQ_STEPS];
  logic [SQ_IN_W-1:0] rem_d [SQ_STEPS];
  logic [SQ_IN_W-1:0] acc_d [SQ_STEPS];

  // one digit-by-digit step per stage
  always_comb begin
    logic [SQ_IN_W-1:0] rem_in;
    logic [SQ_IN_W-1:0] acc_in;
    logic [SQ_IN_W-1:0] bitv;
    logic [SQ_IN_W:0]   trial;
    for (int i = 0; i < SQ_STEPS; i++) begin
      rem_in = (i == 0) ? rad_i : rem_q[(i == 0) ? 0 : i - 1];
      acc_in = (i == 0) ? '0 : acc_q[(i == 0) ? 0 : i - 1];
      bitv   = {{(SQ_IN_W-1){1'b0}}, 1'b1} << (SQ_IN_W - 2 - 2 * i);
      trial  = {1'b0, acc_in} + {1'b0, bitv};
      if ({1'b0, rem_in} >= trial) begin
        rem_d[i] = rem_in - trial[SQ_IN_W-1:0];
        acc_d[i] = (acc_in >> 1) + bitv;
      end else begin
        rem_d[i] = rem_in;
        acc_d[i] = acc_in >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      acc_q <= acc_d;
    end
  end

  assign root_o = acc_q[SQ_STEPS-1][SQ_OUT_W-1:0];

endmodule

// ===== hw/rtl/dmvf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module dmvf_div import dmvf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic [DIV_Q_W-1:0]   quot_o
);

  logic [DIV_NUM_W-1:0] rem_q [DIV_Q_W];
  logic [DIV_DEN_W-1:0] den_q [DIV_Q_W];
  logic [DIV_Q_W-1:0]   quo_q [DIV_Q_W];
  logic [DIV_NUM_W-1:0] rem_d [DIV_Q_W];
  logic [DIV_DEN_W-1:0] den_d [DIV_Q_W];
  logic [DIV_Q_W-1:0]   quo_d [DIV_Q_W];

  // quotient bits from the top down
  always_comb begin
    logic [DIV_NUM_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_Q_W-1:0]   quo_in;
    logic [DIV_W-1:0]     trial;
    for (int i = 0; i < DIV_Q_W; i++) begin
      rem_in = (i == 0) ? num_i : rem_q[(i == 0) ? 0 : i - 1];
      den_in = (i == 0) ? den_i : den_q[(i == 0) ? 0 : i - 1];
      quo_in = (i == 0) ? '0 : quo_q[(i == 0) ? 0 : i - 1];
      trial  = {{(DIV_W-DIV_DEN_W){1'b0}}, den_in} << (DIV_Q_W - 1 - i);
      den_d[i] = den_in;
      quo_d[i] = quo_in;
      if ({{(DIV_W-DIV_NUM_W){1'b0}}, rem_in} >= trial) begin
        rem_d[i] = rem_in - trial[DIV_NUM_W-1:0];
        quo_d[i][DIV_Q_W-1-i] = 1'b1;
      end else begin
        rem_d[i] = rem_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = quo_q[DIV_Q_W-1];

endmodule

// ===== hw/rtl/dome_mesh_vertex_face_generator.sv =====
// Top level: dome mesh vertex position, texture and face generator.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata: ring_index, vertex_index
//  m_axis    out  tvalid/tready           tdata: position, texture, faces; tuser: status
//  cfg       in   cfg_valid/cfg_ready     cfg_addr register index, cfg_data value
//
// One item per cycle when not stalled.
// The path runs through two 16-stage square-root pipelines in series
// (ring radius, then z), with short reciprocal-multiply dividers between.
// Reset clears all valid flags and loads radius 256, resolution 8, 8 rings.
// Stalls freeze the whole pipeline; an output register plus a skid entry
// keep s_axis_tready_o a registered signal.
module dome_mesh_vertex_face_generator import dmvf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [5:0] ring_index, [13:6] vertex_index, [15:14] zero
  input  logic [15:0]            s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [16:0] pos_x, [32:17] pos_y, [49:33] pos_z, [65:50] tex_u, [80:66] tex_v,
  // [94:81] tri_one_a, [108:95] tri_one_b, [122:109] tri_one_c,
  // [136:123] tri_two_a, [150:137] tri_two_b, [164:151] tri_two_c, [167:165] zero
  output logic [TDATA_OUT_W-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]             m_axis_tuser_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_addr_i,
  input  logic [15:0]            cfg_data_i
);

  `include "dome_mesh_vertex_face_generator_assert.svh"

  logic [15:0] radius_q;
  logic [6:0]  res_q;
  logic [6:0]  rings_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      res_q    <= 7'd8;
      rings_q  <= 7'd8;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_RADIUS:     radius_q <= cfg_data_i;
        REG_RESOLUTION: res_q    <= cfg_data_i[6:0];
        REG_RING_COUNT: rings_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // reciprocal table: floor(2^23 / d)
  logic [23:0] recip_tab [128];
  for (genvar g = 0; g < 128; g++) begin : g_rcp
    localparam int unsigned DivG = (g == 0) ? 1 : g;
    localparam int unsigned RcpVal = (g == 0) ? 0 : (1 << 23) / DivG;
    assign recip_tab[g] = 24'(RcpVal);
  end

  logic adv;
  logic v_q [DEPTH];
  side_t ch_q [DEPTH];
  side_t ch_d [DEPTH];

  // entry decode
  side_t       entry;
  logic [23:0] ay_d;
  always_comb begin
    logic [5:0]  s;
    logic [7:0]  k;
    logic [9:0]  k10;
    logic [9:0]  r10;
    logic [9:0]  r3;
    logic [9:0]  cm;
    logic [8:0]  m9;
    logic [14:0] cur;
    logic [14:0] prv;
    logic [14:0] kk;
    logic [14:0] mm;
    logic [22:0] sr;
    s   = s_axis_tdata_i[5:0];
    k   = s_axis_tdata_i[13:6];
    k10 = 10'(k);
    r10 = 10'(res_q);
    r3  = r10 + (r10 << 1);
    m9  = {res_q, 2'b00};
    entry = '0;
    entry.err = (radius_q == 16'd0) || (res_q == 7'd0) ||
                (res_q > 7'(MAX_RESOLUTION)) || (rings_q == 7'd0) ||
                (rings_q > 7'(MAX_RINGS)) || ({1'b0, s} >= rings_q) ||
                ({1'b0, k} >= m9);
    entry.back  = k10 >= (r10 << 1);
    entry.first = (s == 6'd0);
    if (!entry.back) begin
      entry.xneg = k10 < r10;
      cm = entry.xneg ? r10 - k10 : k10 - r10;
    end else begin
      entry.xneg = k10 > r3;
      cm = entry.xneg ? k10 - r3 : r3 - k10;
    end
    entry.cmag = cm[6:0];
    // faces joining this column to the ring below
    mm  = 15'(m9);
    kk  = 15'(k);
    cur = 15'(s) * mm;
    prv = cur - mm;
    if (({1'b0, k} + 9'd1) < m9) begin
      entry.corner[0] = 14'(cur + kk + 15'd1);
      entry.corner[1] = 14'(cur + kk);
      entry.corner[2] = 14'(prv + kk);
      entry.corner[3] = 14'(prv + kk);
      entry.corner[4] = 14'(prv + kk + 15'd1);
      entry.corner[5] = 14'(cur + kk + 15'd1);
    end else begin
      entry.corner[0] = cur[13:0];
      entry.corner[1] = 14'(cur + mm - 15'd1);
      entry.corner[2] = 14'(cur - 15'd1);
      entry.corner[3] = cur[13:0];
      entry.corner[4] = 14'(cur - 15'd1);
      entry.corner[5] = prv[13:0];
    end
    // rounded height numerator: 2*(s+1)*R + N
    sr   = 23'(7'(s) + 7'd1) * 23'(radius_q);
    ay_d = {sr, 1'b0} + 24'(rings_q);
  end

  // transient arithmetic registers
  logic [23:0] ay_q, ay1_q, a2_q, a2b_q;
  logic [15:0] qy_q, qx_q, r1_q, r2_q, r3_q;
  logic [31:0] ysq_q, rsq_q, v_rad_q, xsq_q, rsq2_q, v2_rad_q;
  logic [15:0] r_root, z_root;
  logic [14:0] texv_quo, texu_quo;
  logic [47:0] py, px;
  logic [15:0] y_fix, x_fix;

  assign py = 48'(ay_q) * 48'(recip_tab[rings_q]);
  assign px = 48'(a2_q) * 48'(recip_tab[res_q]);

  // height: correct the reciprocal estimate by one
  always_comb begin
    logic [23:0] dn;
    logic [23:0] rm;
    dn    = 24'({rings_q, 1'b0});
    rm    = ay1_q - 24'(qy_q) * dn;
    y_fix = (rm >= dn) ? qy_q + 16'd1 : qy_q;
  end

  // x magnitude: same correction, clamped to the ring radius
  always_comb begin
    logic [23:0] dn;
    logic [23:0] rm;
    logic [15:0] xc;
    dn    = 24'({res_q, 1'b0});
    rm    = a2b_q - 24'(qx_q) * dn;
    xc    = (rm >= dn) ? qx_q + 16'd1 : qx_q;
    x_fix = (xc > r2_q) ? r2_q : xc;
  end

  // side-band chain with fields filled in at their stages
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ch_d[i] = (i == 0) ? entry : ch_q[(i == 0) ? 0 : i - 1];
      if (i == Y_ST)  ch_d[i].y    = y_fix;
      if (i == X_ST)  ch_d[i].xmag = x_fix;
      if (i == TV_ST) ch_d[i].texv = texv_quo;
      if (i == TU_ST) ch_d[i].texu = texu_quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ch_q     <= ch_d;
      ay_q     <= ay_d;
      qy_q     <= py[39:24];
      ay1_q    <= ay_q;
      ysq_q    <= 32'(ch_q[Y_ST].y) * 32'(ch_q[Y_ST].y);
      rsq_q    <= 32'(radius_q) * 32'(radius_q);
      v_rad_q  <= rsq_q - ysq_q;
      a2_q     <= {23'(ch_q[R_ST].cmag) * 23'(r_root), 1'b0} + 24'(res_q);
      r1_q     <= r_root;
      qx_q     <= px[39:24];
      a2b_q    <= a2_q;
      r2_q     <= r1_q;
      r3_q     <= r2_q;
      xsq_q    <= 32'(ch_q[X_ST].xmag) * 32'(ch_q[X_ST].xmag);
      rsq2_q   <= 32'(r3_q) * 32'(r3_q);
      v2_rad_q <= rsq2_q - xsq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= s_axis_tvalid_i;
      for (int i = 1; i < DEPTH; i++) v_q[i] <= v_q[i-1];
    end
  end

  dmvf_isqrt u_sqrt_ring (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (v_rad_q),
    .root_o (r_root)
  );

  dmvf_isqrt u_sqrt_z (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (v2_rad_q),
    .root_o (z_root)
  );

  dmvf_div u_div_texv (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (32'({ch_q[Y_ST].y, 15'd0}) + 32'(radius_q)),
    .den_i  ({radius_q, 1'b0}),
    .quot_o (texv_quo)
  );

  dmvf_div u_div_texu (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (32'({ch_q[X_ST].xmag, 15'd0}) + 32'(radius_q)),
    .den_i  ({radius_q, 1'b0}),
    .quot_o (texu_quo)
  );

  // result assembly
  out_t res_new;
  always_comb begin
    side_t       it;
    logic [16:0] pxs;
    logic [16:0] pzs;
    logic [15:0] tus;
    logic [5:0][13:0] tr;
    it  = ch_q[LAST_ST];
    pxs = (it.xneg && it.xmag != 16'd0) ? 17'd0 - 17'(it.xmag) : 17'(it.xmag);
    pzs = it.back ? 17'd0 - 17'(z_root) : 17'(z_root);
    tus = (it.xneg && it.texu != 15'd0) ? 16'd0 - 16'(it.texu) : 16'(it.texu);
    tr  = it.first ? '0 : it.corner;
    res_new = '0;
    if (it.err) begin
      res_new.tuser = ST_ERROR;
    end else begin
      res_new.tuser = it.first ? ST_VERTEX : ST_FACES;
      res_new.tdata = {3'b000, tr[5], tr[4], tr[3], tr[2], tr[1], tr[0],
                       it.texv, tus, pzs, it.y, pxs};
    end
  end

  // output register with one skid entry
  out_t out_q, skid_q;
  logic out_valid_q, skid_valid_q, take;

  assign adv             = !skid_valid_q;
  assign s_axis_tready_o = adv;
  assign take            = out_valid_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take && skid_valid_q) begin
      skid_valid_q <= 1'b0;
    end else if (adv && v_q[LAST_ST]) begin
      if (!out_valid_q || take) out_valid_q <= 1'b1;
      else skid_valid_q <= 1'b1;
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && skid_valid_q) begin
      out_q <= skid_q;
    end else if (adv && v_q[LAST_ST]) begin
      if (!out_valid_q || take) out_q <= res_new;
      else skid_q <= res_new;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.tdata;
  assign m_axis_tuser_o  = out_q.tuser;

  `DMVF_ASSERT_ALWAYS(a_skid_behind_out, !rst_ni || !skid_valid_q || out_valid_q)
  `DMVF_ASSERT(a_err_zero, (m_axis_tvalid_o && m_axis_tuser_o == ST_ERROR) |-> (m_axis_tdata_o == '0))
  `DMVF_ASSERT(a_low_ring_no_faces, (m_axis_tvalid_o && m_axis_tuser_o == ST_VERTEX) |-> (m_axis_tdata_o[164:81] == '0))

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the dome mesh vertex and face generator.
module tb_top import dmvf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY   = 42;
  localparam int unsigned CYCLE_CAP = 400000;

  // one expected vertex result
  typedef struct packed {
    logic [TDATA_OUT_W-1:0] tdata;
    logic [1:0]             status;
  } vertex_t;

  // directed stimulus row; pin_err marks rows whose predicted status must be ST_ERROR
  typedef struct {
    int unsigned ring;
    int unsigned vert;
    logic        pin_err;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_addr_i = '0;
  logic [15:0] cfg_data_i = '0;

  dome_mesh_vertex_face_generator uut (.*);

  always #2 clk_i = ~clk_i;

  // dome geometry registers as the predictor sees them
  longint unsigned radius_q = 256, quarter_res = 8, rings = 8;
  vertex_t expected_q[$];
  int unsigned mismatches = 0, results_seen = 0, items_sent = 0, face_results = 0;
  int unsigned cycles = 0;
  bit sink_calm = 1'b0;
  bit src_calm  = 1'b0;

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned acc = 0, bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    return (num * 2 + den) / (den * 2);
  endfunction

  // predicted vertex position, texture coordinates and faces
  function automatic vertex_t dome_vertex(longint unsigned s, longint unsigned k);
    vertex_t v;
    longint unsigned m, y, r, cmag, xmag, zmag, umag, cur, prev;
    logic [13:0] t[6];
    bit back, xneg;
    v = '0;
    m = quarter_res * 4;
    if (radius_q == 0 || quarter_res == 0 || quarter_res > MAX_RESOLUTION || rings == 0 ||
        rings > MAX_RINGS || s >= rings || k >= m) begin
      v.status = ST_ERROR;
      return v;
    end
    y = round_div((s + 1) * radius_q, rings);
    r = sqrt_floor(radius_q * radius_q - y * y);
    back = k >= 2 * quarter_res;
    if (!back) begin
      xneg = k < quarter_res;
      cmag = xneg ? quarter_res - k : k - quarter_res;
    end else begin
      xneg = k > 3 * quarter_res;
      cmag = xneg ? k - 3 * quarter_res : 3 * quarter_res - k;
    end
    xmag = round_div(cmag * r, quarter_res);
    if (xmag > r) xmag = r;
    zmag = sqrt_floor(r * r - xmag * xmag);
    umag = round_div(xmag * 16384, radius_q);
    v.tdata[16:0]  = (xneg && xmag != 0) ? 17'(-xmag) : 17'(xmag);
    v.tdata[32:17] = 16'(y);
    v.tdata[49:33] = back ? 17'(-zmag) : 17'(zmag);
    v.tdata[65:50] = (xneg && umag != 0) ? 16'(-umag) : 16'(umag);
    v.tdata[80:66] = 15'(round_div(y * 16384, radius_q));
    if (s == 0) begin
      v.status = ST_VERTEX;
      return v;
    end
    v.status = ST_FACES;
    cur = s * m;
    prev = (s - 1) * m;
    if (k < m - 1) begin
      t = '{14'(cur + k + 1), 14'(cur + k), 14'(prev + k),
            14'(prev + k), 14'(prev + k + 1), 14'(cur + k + 1)};
    end else begin
      t = '{14'(cur), 14'(cur + m - 1), 14'(cur - 1), 14'(cur), 14'(cur - 1), 14'(prev)};
    end
    for (int i = 0; i < 6; i++) v.tdata[81 + 14 * i +: 14] = t[i];
    return v;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, what, got, want);
  endtask

  // result sink: random backpressure outside the calm phase, field-by-field compare
  always @(posedge clk_i) begin
    vertex_t want;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tuser_o, 0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tuser_o != want.status) report_mismatch("status", m_axis_tuser_o, want.status);
        if (m_axis_tdata_o[16:0] != want.tdata[16:0])
          report_mismatch("pos_x", m_axis_tdata_o[16:0], want.tdata[16:0]);
        if (m_axis_tdata_o[32:17] != want.tdata[32:17])
          report_mismatch("pos_y", m_axis_tdata_o[32:17], want.tdata[32:17]);
        if (m_axis_tdata_o[49:33] != want.tdata[49:33])
          report_mismatch("pos_z", m_axis_tdata_o[49:33], want.tdata[49:33]);
        if (m_axis_tdata_o[65:50] != want.tdata[65:50])
          report_mismatch("tex_u", m_axis_tdata_o[65:50], want.tdata[65:50]);
        if (m_axis_tdata_o[80:66] != want.tdata[80:66])
          report_mismatch("tex_v", m_axis_tdata_o[80:66], want.tdata[80:66]);
        for (int i = 0; i < 6; i++)
          if (m_axis_tdata_o[81 + 14 * i +: 14] != want.tdata[81 + 14 * i +: 14])
            report_mismatch($sformatf("triangle corner %0d", i),
                            m_axis_tdata_o[81 + 14 * i +: 14], want.tdata[81 + 14 * i +: 14]);
        if (m_axis_tdata_o[167:165] != 3'd0) report_mismatch("pad", m_axis_tdata_o[167:165], 0);
        if (want.status == ST_FACES) face_results++;
      end
      results_seen++;
    end
    m_axis_tready_i <= sink_calm ? 1'b1 : ($urandom_range(99) >= 36);
  end

  // timeout watchdog
  always @(posedge clk_i) begin
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // valid stays high between back-to-back writes; the caller drops it
  task automatic write_reg(cfg_reg_e idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_RADIUS:     radius_q = value;
      REG_RESOLUTION: quarter_res = value[6:0];
      default:        rings = value[6:0];
    endcase
  endtask

  task automatic drain;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic configure(logic [15:0] rad, logic [15:0] res, logic [15:0] cnt);
    drain();
    write_reg(REG_RADIUS, rad);
    write_reg(REG_RESOLUTION, res);
    write_reg(REG_RING_COUNT, cnt);
    cfg_valid_i <= 1'b0;
  endtask

  // drive one item; rises valid after optional idle cycles
  task automatic send_vertex(int unsigned ring, int unsigned vert);
    if (!src_calm)
      while ($urandom_range(99) < 36) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {2'b00, vert[7:0], ring[5:0]};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_q.push_back(dome_vertex(ring[5:0], vert[7:0]));
    items_sent++;
  endtask

  task automatic idle_source;
    s_axis_tvalid_i <= 1'b0;
  endtask

  // random burst; mostly legal indices under the current geometry
  task automatic random_burst(int unsigned count);
    int unsigned s, k;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        s = $urandom_range(63);
        k = $urandom_range(255);
      end else begin
        s = $urandom_range(rings - 1);
        k = $urandom_range(quarter_res * 4 - 1);
      end
      send_vertex(s, k);
    end
    idle_source();
  endtask

  dir_row_t directed[] = '{
    '{0, 0, 0}, '{0, 8, 0}, '{0, 16, 0}, '{0, 24, 0}, '{0, 31, 0},
    '{1, 0, 0}, '{1, 30, 0}, '{1, 31, 0}, '{7, 0, 0}, '{7, 31, 0},
    '{4, 7, 0}, '{4, 9, 0}, '{4, 23, 0}, '{4, 25, 0},
    '{8, 0, 1}, '{63, 0, 1}, '{0, 32, 1}, '{0, 255, 1}, '{63, 255, 1}
  };

  initial begin
    vertex_t check;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at reset geometry
    foreach (directed[i]) begin
      check = dome_vertex(directed[i].ring, directed[i].vert);
      if (directed[i].pin_err && check.status != ST_ERROR)
        report_mismatch("directed error row", check.status, ST_ERROR);
      send_vertex(directed[i].ring, directed[i].vert);
    end
    idle_source();

    // extremes and bad settings
    configure(16'hFFFF, 64, 64);
    send_vertex(63, 255); send_vertex(63, 0); send_vertex(0, 128); send_vertex(62, 255);
    idle_source();
    configure(1, 1, 1);
    send_vertex(0, 0); send_vertex(0, 3); send_vertex(0, 4); send_vertex(1, 0);
    idle_source();
    configure(0, 0, 0);
    send_vertex(0, 0);
    idle_source();
    configure(256, 65, 127);
    send_vertex(0, 0);
    idle_source();

    // random geometries
    for (int ph = 0; ph < 14; ph++) begin
      configure($urandom_range(65535, 1), $urandom_range(64, 1), $urandom_range(64, 1));
      sink_calm = (ph == 5);
      src_calm = (ph == 5);
      random_burst(100);
    end
    configure(16'hFFFF, 64, 64);
    random_burst(40);

    drain();
    $display("Sent %0d items, checked %0d results (%0d with faces) across 20 geometries",
             items_sent, results_seen, face_results);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dmvf_pkg.sv
hw/rtl/dmvf_isqrt.sv
hw/rtl/dmvf_div.sv
hw/rtl/dome_mesh_vertex_face_generator.sv
dv/tb_top.sv
